// File: hw/rtl/glyph_bitmap_blitter_defines.svh
`ifndef GLYPH_BITMAP_BLITTER_DEFINES_SVH
`define GLYPH_BITMAP_BLITTER_DEFINES_SVH

// same-cycle implication
`define GBB_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gbb check failed");

// next-cycle implication
`define GBB_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gbb check failed");

`endif

// File: hw/rtl/gbb_pkg.sv
package gbb_pkg;

	localparam int FONT_BYTES = 2048;
	localparam int FONT_AW    = $clog2(FONT_BYTES);

	localparam int S_DATA_W = 128;
	localparam int S_USER_W = 2;
	localparam int M_DATA_W = 64;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 4;

	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 1'd1;

	localparam logic [3:0] SIZE_RESET = 4'd8;
	localparam logic [3:0] SIZE_MAX   = 4'd8;
	localparam logic [3:0] SIZE_MIN   = 4'd1;

	localparam logic [1:0] MODE_LOAD   = 2'd0;
	localparam logic [1:0] MODE_TRANSP = 2'd1;
	localparam logic [1:0] MODE_OPAQUE = 2'd2;
	localparam logic [1:0] MODE_NONE   = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [10:0] font_index;
		logic [7:0]  font_byte;
		logic [7:0]  char_code;
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic [31:0] fg_color;
		logic [31:0] bg_color;
	} item_t;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [31:0] color;
	} pixel_t;

	typedef struct packed {
		logic push;
		logic flush;
	} emit_ctl_t;

	typedef struct packed {
		logic pend_valid;
		logic out_free;
	} emit_sts_t;

	function automatic logic [3:0] clamp_size(input logic [3:0] v);
		logic [3:0] r;
		r = v;
		if (v < SIZE_MIN) r = SIZE_MIN;
		else if (v > SIZE_MAX) r = SIZE_MAX;
		return r;
	endfunction

endpackage

// File: hw/rtl/glyph_bitmap_blitter.sv
// Character generator. A load item (tuser 0) writes one byte into the 2048-entry
// font store. A draw item (tuser 1 transparent, 2 opaque) reads glyph_height
// rows starting at char_code*glyph_height and scans each row from bit 7 for
// glyph_width columns, one column a cycle while the output does not stall, after
// a font store read for the row: s_tready stays low until the draw is done, also
// while m_tready holds output back. One pixel is held back internally so that
// tlast marks the final pixel of each glyph. Font entries must be loaded before
// any draw reads them. Sizes of 0 act as 1 and sizes above 8 act as 8; write the
// size registers only while the block is idle.
module glyph_bitmap_blitter (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// font_index, font_byte, char_code, origin_x, origin_y, fg_color, bg_color
	input  logic [gbb_pkg::S_DATA_W-1:0]     s_tdata,
	// mode
	input  logic [gbb_pkg::S_USER_W-1:0]     s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// pixel_x, pixel_y, pixel_color
	output logic [gbb_pkg::M_DATA_W-1:0]     m_tdata,
	output logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [gbb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gbb_pkg::CFG_DATA_W-1:0]   cfg_data
);

	gbb_pkg::item_t     item;
	gbb_pkg::pixel_t    pix, m_pix;
	gbb_pkg::emit_ctl_t ctl;
	gbb_pkg::emit_sts_t sts;

	logic [3:0] cfg_w_q, cfg_h_q;

	logic                        mem_we, mem_re;
	logic [gbb_pkg::FONT_AW-1:0] mem_waddr, mem_raddr;
	logic [7:0]                  mem_wdata, mem_rdata;

	assign item.mode       = s_tuser;
	assign item.font_index = s_tdata[10:0];
	assign item.font_byte  = s_tdata[18:11];
	assign item.char_code  = s_tdata[26:19];
	assign item.origin_x   = s_tdata[42:27];
	assign item.origin_y   = s_tdata[58:43];
	assign item.fg_color   = s_tdata[90:59];
	assign item.bg_color   = s_tdata[122:91];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= gbb_pkg::SIZE_RESET;
			cfg_h_q <= gbb_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gbb_pkg::REG_GLYPH_WIDTH:  cfg_w_q <= cfg_data;
				gbb_pkg::REG_GLYPH_HEIGHT: cfg_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	gbb_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.item      (item),
		.cfg_w     (cfg_w_q),
		.cfg_h     (cfg_h_q),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata),
		.ctl       (ctl),
		.pix       (pix),
		.sts       (sts)
	);

	gbb_font_mem u_font (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	gbb_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.pix      (pix),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_pix    (m_pix),
		.m_last   (m_tlast)
	);

	assign m_tdata = {m_pix.color, m_pix.y, m_pix.x};

endmodule

// File: hw/rtl/gbb_font_mem.sv
module gbb_font_mem (
	input  logic                        clk,
	input  logic                        we,
	input  logic [gbb_pkg::FONT_AW-1:0] waddr,
	input  logic [7:0]                  wdata,
	input  logic                        re,
	input  logic [gbb_pkg::FONT_AW-1:0] raddr,
	output logic [7:0]                  rdata
);

	logic [7:0] mem [gbb_pkg::FONT_BYTES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/gbb_emit.sv
module gbb_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  gbb_pkg::emit_ctl_t ctl,
	input  gbb_pkg::pixel_t    pix,
	output gbb_pkg::emit_sts_t sts,
	output logic               m_tvalid,
	input  logic               m_tready,
	output gbb_pkg::pixel_t    m_pix,
	output logic               m_last
);

	logic            pend_valid_q;
	gbb_pkg::pixel_t pend_q;
	logic            out_valid_q;
	gbb_pkg::pixel_t out_q;
	logic            out_last_q;

	assign sts.pend_valid = pend_valid_q;
	assign sts.out_free   = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (ctl.push) begin
				pend_valid_q <= 1'b1;
				if (pend_valid_q) begin
					out_valid_q <= 1'b1;
				end else if (m_tready) begin
					out_valid_q <= 1'b0;
				end
			end else if (ctl.flush) begin
				pend_valid_q <= 1'b0;
				out_valid_q  <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			pend_q <= pix;
			if (pend_valid_q) begin
				out_q      <= pend_q;
				out_last_q <= 1'b0;
			end
		end else if (ctl.flush) begin
			out_q      <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_pix    = out_q;
	assign m_last   = out_last_q;

endmodule

// File: hw/rtl/gbb_seq.sv
module gbb_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  gbb_pkg::item_t              item,
	input  logic [3:0]                  cfg_w,
	input  logic [3:0]                  cfg_h,
	output logic                        mem_we,
	output logic [gbb_pkg::FONT_AW-1:0] mem_waddr,
	output logic [7:0]                  mem_wdata,
	output logic                        mem_re,
	output logic [gbb_pkg::FONT_AW-1:0] mem_raddr,
	input  logic [7:0]                  mem_rdata,
	output gbb_pkg::emit_ctl_t          ctl,
	output gbb_pkg::pixel_t             pix,
	input  gbb_pkg::emit_sts_t          sts
);

	gbb_pkg::state_t state_q, state_d;

	logic        opaque_q;
	logic [3:0]  w_q, h_q;
	logic [11:0] base_q;
	logic [15:0] ox_q, oy_q;
	logic [31:0] fg_q, bg_q;
	logic [2:0]  row_q, col_q;

	logic        accept, is_draw;
	logic        bit_set, emit, stall;
	logic        col_last, row_last;
	logic [11:0] glyph_addr;
	logic [3:0]  w_new, h_new;

	assign accept  = s_tvalid && s_tready;
	assign is_draw = (item.mode == gbb_pkg::MODE_TRANSP) || (item.mode == gbb_pkg::MODE_OPAQUE);
	assign w_new   = gbb_pkg::clamp_size(cfg_w);
	assign h_new   = gbb_pkg::clamp_size(cfg_h);

	assign col_last   = ({1'b0, col_q} == (w_q - 4'd1));
	assign row_last   = ({1'b0, row_q} == (h_q - 4'd1));
	assign glyph_addr = base_q + {9'd0, row_q};
	assign bit_set    = mem_rdata[3'd7 - col_q];
	assign emit       = opaque_q || bit_set;
	assign stall      = emit && sts.pend_valid && !sts.out_free;

	assign pix.x     = ox_q + {13'd0, col_q};
	assign pix.y     = oy_q + {13'd0, row_q};
	assign pix.color = bit_set ? fg_q : bg_q;

	assign mem_waddr = gbb_pkg::FONT_AW'(item.font_index);
	assign mem_wdata = item.font_byte;
	assign mem_raddr = gbb_pkg::FONT_AW'(glyph_addr);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gbb_pkg::ST_IDLE: begin
				if (accept && is_draw) state_d = gbb_pkg::ST_FETCH;
			end
			gbb_pkg::ST_FETCH: begin
				state_d = gbb_pkg::ST_SCAN;
			end
			gbb_pkg::ST_SCAN: begin
				if (!stall && col_last) begin
					state_d = row_last ? gbb_pkg::ST_FLUSH : gbb_pkg::ST_FETCH;
				end
			end
			gbb_pkg::ST_FLUSH: begin
				if (!sts.pend_valid || sts.out_free) state_d = gbb_pkg::ST_IDLE;
			end
			default: state_d = gbb_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		s_tready  = 1'b0;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		ctl.push  = 1'b0;
		ctl.flush = 1'b0;
		unique case (state_q)
			gbb_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				mem_we   = s_tvalid && (item.mode == gbb_pkg::MODE_LOAD);
			end
			gbb_pkg::ST_FETCH: begin
				mem_re = 1'b1;
			end
			gbb_pkg::ST_SCAN: begin
				ctl.push = emit && !stall;
			end
			gbb_pkg::ST_FLUSH: begin
				ctl.flush = sts.pend_valid && sts.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbb_pkg::ST_IDLE;
			row_q   <= 3'd0;
			col_q   <= 3'd0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				row_q <= 3'd0;
				col_q <= 3'd0;
			end else if (state_q == gbb_pkg::ST_SCAN && !stall) begin
				if (col_last) begin
					col_q <= 3'd0;
					row_q <= row_q + 3'd1;
				end else begin
					col_q <= col_q + 3'd1;
				end
			end
		end
	end

	// draw parameters latched per draw item
	always_ff @(posedge clk) begin
		if (accept && is_draw) begin
			opaque_q <= (item.mode == gbb_pkg::MODE_OPAQUE);
			w_q      <= w_new;
			h_q      <= h_new;
			base_q   <= {4'd0, item.char_code} * {8'd0, h_new};
			ox_q     <= item.origin_x;
			oy_q     <= item.origin_y;
			fg_q     <= item.fg_color;
			bg_q     <= item.bg_color;
		end
	end

endmodule

// File: hw/rtl/gbb_checker.sv
`include "glyph_bitmap_blitter_defines.svh"

module gbb_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [gbb_pkg::S_USER_W-1:0]   s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [gbb_pkg::M_DATA_W-1:0]   m_tdata,
	input logic                           m_tlast
);

	logic s_acc;
	logic s_draw;
	assign s_acc  = s_tvalid && s_tready;
	assign s_draw = (s_tuser == gbb_pkg::MODE_TRANSP) || (s_tuser == gbb_pkg::MODE_OPAQUE);

	// a stalled result holds
	`GBB_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

	// a draw item keeps the input side busy
	`GBB_ASSERT_NXT(a_draw_busy, s_acc && s_draw, !s_tready)

	// a load item leaves the input side ready
	`GBB_ASSERT_NXT(a_load_quick, s_acc && s_tuser == gbb_pkg::MODE_LOAD, s_tready)

	// an unused mode is dropped
	`GBB_ASSERT_NXT(a_none_quick, s_acc && s_tuser == gbb_pkg::MODE_NONE, s_tready)

endmodule

bind glyph_bitmap_blitter gbb_checker u_gbb_checker (.*);

// File: tb/glyph_bitmap_blitter_checker.sv
`timescale 1ns / 1ps

module glyph_bitmap_blitter_checker
	import gbb_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_DATA_W-1:0]   s_tdata,
	input  logic [S_USER_W-1:0]   s_tuser,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_DATA_W-1:0]   m_tdata,
	input  logic                  m_tlast,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending
);

	typedef struct packed {
		logic [4:0]  pad;
		logic [31:0] bg_color;
		logic [31:0] fg_color;
		logic [15:0] origin_y;
		logic [15:0] origin_x;
		logic [7:0]  char_code;
		logic [7:0]  font_byte;
		logic [10:0] font_index;
	} glyph_req_t;

	typedef struct packed {
		logic [31:0] color;
		logic [15:0] y;
		logic [15:0] x;
	} pixel_word_t;

	typedef struct packed {
		pixel_word_t px;
		logic        last;
	} pixel_exp_t;

	logic [7:0]  font_shadow [FONT_BYTES];
	logic [3:0]  width_reg;
	logic [3:0]  height_reg;
	pixel_exp_t  pixel_queue [$];
	int          err_count = 0;

	function automatic int size_eff(input logic [3:0] v);
		if (v == 4'd0)
			return 1;
		if (v > 4'd8)
			return 8;
		return int'(v);
	endfunction

	task automatic expect_glyph(input logic [1:0] mode, input glyph_req_t req);
		int         w;
		int         h;
		int         addr;
		logic [7:0] bits;
		logic       hit;
		logic       have_held;
		pixel_exp_t held;
		w = size_eff(width_reg);
		h = size_eff(height_reg);
		have_held = 1'b0;
		held = '0;
		for (int row = 0; row < h; row++) begin
			addr = (int'(req.char_code) * h + row) % FONT_BYTES;
			bits = font_shadow[addr];
			for (int col = 0; col < w; col++) begin
				hit = bits[7 - col];
				if (mode == MODE_OPAQUE || hit) begin
					// hold one back so the final pixel can be marked last
					if (have_held)
						pixel_queue.push_back(held);
					held.px.x = req.origin_x + 16'(col);
					held.px.y = req.origin_y + 16'(row);
					held.px.color = hit ? req.fg_color : req.bg_color;
					held.last = 1'b0;
					have_held = 1'b1;
				end
			end
		end
		if (have_held) begin
			held.last = 1'b1;
			pixel_queue.push_back(held);
		end
	endtask

	task automatic take_item(input logic [1:0] mode, input glyph_req_t req);
		case (mode)
			MODE_LOAD: begin
				font_shadow[req.font_index] = req.font_byte;
			end
			MODE_TRANSP, MODE_OPAQUE: begin
				expect_glyph(mode, req);
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_pixel(input pixel_word_t got, input logic got_last);
		pixel_exp_t want;
		if (pixel_queue.size() == 0) begin
			$error("pixel: none expected, got x %0d y %0d color %h", got.x, got.y, got.color);
			err_count++;
		end else begin
			want = pixel_queue.pop_front();
			if (want.px.x !== got.x) begin
				$error("pixel_x: expected %0d, got %0d", want.px.x, got.x);
				err_count++;
			end
			if (want.px.y !== got.y) begin
				$error("pixel_y: expected %0d, got %0d", want.px.y, got.y);
				err_count++;
			end
			if (want.px.color !== got.color) begin
				$error("pixel_color: expected %h, got %h", want.px.color, got.color);
				err_count++;
			end
			if (want.last !== got_last) begin
				$error("last: expected %0d, got %0d", want.last, got_last);
				err_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = SIZE_RESET;
			height_reg = SIZE_RESET;
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_GLYPH_WIDTH: width_reg = cfg_data;
					REG_GLYPH_HEIGHT: height_reg = cfg_data;
					default: begin
					end
				endcase
			end
			if (s_tvalid && s_tready)
				take_item(s_tuser, glyph_req_t'(s_tdata));
			if (m_tvalid && m_tready)
				check_pixel(pixel_word_t'(m_tdata), m_tlast);
			errors <= err_count;
			pending <= pixel_queue.size();
		end
	end

endmodule

// File: tb/tb_glyph_bitmap_blitter.sv
`timescale 1ns / 1ps

module tb_glyph_bitmap_blitter;
	import gbb_pkg::*;

	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 100;
	localparam int PHASE_ITEMS  = 31;
	localparam int FIXED_PHASES = 9;

	localparam logic [7:0] EDGE_ROWS [8] = '{8'hFF, 8'h00, 8'h80, 8'h01,
		8'hAA, 8'h55, 8'hF0, 8'h0F};
	localparam logic [3:0] PHASE_W [FIXED_PHASES] = '{4'd1, 4'd0, 4'd8, 4'd1, 4'd15,
		4'd8, 4'd3, 4'd5, 4'd2};
	localparam logic [3:0] PHASE_H [FIXED_PHASES] = '{4'd1, 4'd15, 4'd1, 4'd8, 4'd0,
		4'd8, 4'd5, 4'd2, 4'd7};

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_SHORT,
		STALL_LONG
	} stall_style_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic [S_DATA_W-1:0]   s_tdata = '0;
	logic [S_USER_W-1:0]   s_tuser = '0;
	logic                  m_tready = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tready;
	logic                  m_tvalid;
	logic [M_DATA_W-1:0]   m_tdata;
	logic                  m_tlast;
	int                    errors;
	int                    pending;

	logic         font_loaded [FONT_BYTES];
	int           rows_eff = 8;
	int           burst_left = 0;
	int           items_sent = 0;
	int           idle_cycles = 0;
	int           stall_left = 0;
	int           style_age = 0;
	stall_style_t stall_style = STALL_NONE;

	glyph_bitmap_blitter i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	glyph_bitmap_blitter_checker i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// pixel sink: stall style is picked anew when style_age runs out
	always @(posedge clk) begin
		if (style_age == 0) begin
			stall_style = stall_style_t'($urandom_range(0, 2));
			style_age = $urandom_range(50, 300);
		end
		style_age--;
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else begin
			m_tready <= 1'b1;
			if (stall_style == STALL_SHORT && $urandom_range(0, 2) == 0)
				stall_left = $urandom_range(1, 3);
			else if (stall_style == STALL_LONG && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(4, 15);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	function automatic logic [S_DATA_W-1:0] pack_item(input logic [10:0] idx,
		input logic [7:0] bits, input logic [7:0] code, input logic [15:0] ox,
		input logic [15:0] oy, input logic [31:0] fg, input logic [31:0] bg);
		logic [S_DATA_W-1:0] word;
		word = '0;
		word[122:0] = {bg, fg, oy, ox, code, bits, idx};
		return word;
	endfunction

	function automatic logic [7:0] glyph_bits();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic send(input logic [1:0] mode, input logic [S_DATA_W-1:0] data);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			repeat (gap) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		burst_left--;
		if (mode != MODE_NONE)
			items_sent++;
	endtask

	task automatic load_row(input int addr, input logic [7:0] bits);
		send(MODE_LOAD, pack_item(11'(addr), bits, 8'($urandom), 16'($urandom),
			16'($urandom), $urandom, $urandom));
		font_loaded[addr] = 1'b1;
	endtask

	task automatic draw(input logic [1:0] mode, input logic [7:0] code,
		input logic [15:0] ox, input logic [15:0] oy, input logic [31:0] fg,
		input logic [31:0] bg);
		send(mode, pack_item(11'($urandom), 8'($urandom), code, ox, oy, fg, bg));
	endtask

	// every row a draw will read must be loaded first
	task automatic prepare_glyph(input logic [7:0] code);
		int addr;
		for (int r = 0; r < rows_eff; r++) begin
			addr = (int'(code) * rows_eff + r) % FONT_BYTES;
			if (!font_loaded[addr] || $urandom_range(0, 3) == 0)
				load_row(addr, glyph_bits());
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		burst_left = 0;
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [3:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic configure(input logic [3:0] w, input logic [3:0] h);
		drain();
		cfg_write(REG_GLYPH_WIDTH, w);
		cfg_write(REG_GLYPH_HEIGHT, h);
		cfg_we <= 1'b0;
		rows_eff = (h == 4'd0) ? 1 : (h > 4'd8) ? 8 : int'(h);
	endtask

	task automatic run_phase();
		int         target;
		int         pick;
		logic [7:0] code;
		target = items_sent + PHASE_ITEMS;
		while (items_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				load_row($urandom_range(0, FONT_BYTES - 1), 8'($urandom));
			end else if (pick < 12) begin
				send(MODE_NONE, pack_item(11'($urandom), 8'($urandom), 8'($urandom),
					16'($urandom), 16'($urandom), $urandom, $urandom));
			end else begin
				code = 8'($urandom);
				prepare_glyph(code);
				draw($urandom_range(0, 1) ? MODE_OPAQUE : MODE_TRANSP, code,
					16'($urandom), 16'($urandom), $urandom, $urandom);
			end
		end
	endtask

	initial begin
		for (int i = 0; i < FONT_BYTES; i++)
			font_loaded[i] = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		configure(4'd8, 4'd8);

		// code 0: full, empty, single-bit, alternating and half rows
		for (int r = 0; r < 8; r++)
			load_row(r, EDGE_ROWS[r]);
		draw(MODE_OPAQUE, 8'd0, 16'hFFFC, 16'hFFFE, 32'hFFFF_FFFF, 32'h0);
		draw(MODE_OPAQUE, 8'd0, 16'h0, 16'h0, 32'h0, 32'hFFFF_FFFF);
		draw(MODE_TRANSP, 8'd0, 16'h0, 16'h0, 32'hFFFF_FFFF, 32'h0);
		// code 255 blank, top of the font store
		for (int r = 0; r < 8; r++)
			load_row(FONT_BYTES - 8 + r, 8'h00);
		draw(MODE_TRANSP, 8'd255, 16'h1234, 16'h5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		draw(MODE_OPAQUE, 8'd255, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0);
		send(MODE_NONE, pack_item(11'h7FF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF));

		for (int p = 0; p < FIXED_PHASES; p++) begin
			configure(PHASE_W[p], PHASE_H[p]);
			run_phase();
		end
		for (int p = 0; p < 2; p++) begin
			configure(4'($urandom_range(1, 8)), 4'($urandom_range(1, 8)));
			run_phase();
		end

		drain();
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// File: glyph_bitmap_blitter.f
+incdir+hw/rtl
hw/rtl/gbb_pkg.sv
hw/rtl/gbb_font_mem.sv
hw/rtl/gbb_emit.sv
hw/rtl/gbb_seq.sv
hw/rtl/glyph_bitmap_blitter.sv
hw/rtl/gbb_checker.sv
tb/glyph_bitmap_blitter_checker.sv
tb/tb_glyph_bitmap_blitter.sv
